>>> rtl/ttc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text terminal cursor engine.
package ttc_pkg;

    typedef enum logic [1:0] {
        OP_PUT_CHAR   = 2'd0,
        OP_PUT_NUMBER = 2'd1,
        OP_SET_CURSOR = 2'd2,
        OP_CLEAR      = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_CURSOR = 2'd0,
        KIND_CELL   = 2'd1,
        KIND_FILL   = 2'd2
    } t_result_kind;

    typedef enum logic {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } t_reg_index;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ZERO    = 8'd48;

    localparam int TAB_STEP   = 4;
    localparam int NUM_BITS   = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    localparam int ADDR_W     = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int COLOR_W    = 4;

    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;

endpackage

>>> rtl/text_terminal_cursor_engine.sv
`timescale 1ns / 1ps
// Text terminal cursor engine: cursor tracking, cell writes and decimal printing.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one command item: put character,
//   put number, set cursor or clear. Output channel (o_out_valid / i_out_ready)
//   gives result items: cursor reports, cell writes or one screen fill; each
//   carries the cursor after it, and o_last_result marks an item's final result.
//   Colors are written through i_cfg_we / i_cfg_index / i_cfg_wdata while idle.
//   Put character, set cursor and clear: the single result is registered on
//   acceptance; one item per cycle while the receiver keeps up.
//   Put number: a bit-serial binary to BCD converter shifts in the 64-bit value,
//   leading zeros are then dropped at one digit per cycle, then one digit result
//   per cycle as the receiver takes them; no new item is taken until the last
//   digit is in the output register.
//   Reset homes the cursor, sets colors to 7 on 0 and empties the output register.
//   When the receiver stalls, the output register holds its item and no new
//   input item is taken until the register frees.
module text_terminal_cursor_engine #(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  ttc_pkg::t_reg_index   i_cfg_index,
    input  logic [3:0]            i_cfg_wdata,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ttc_pkg::t_opcode      i_opcode,
    input  logic [7:0]            i_char_code,
    input  logic [63:0]           i_number_value,
    input  logic [7:0]            i_target_row,
    input  logic [7:0]            i_target_column,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ttc_pkg::t_result_kind o_result_kind,
    output logic [10:0]           o_cell_address,
    output logic [15:0]           o_cell_word,
    output logic [4:0]            o_cursor_row_out,
    output logic [6:0]            o_cursor_column_out,
    output logic                  o_last_result
);
    import ttc_pkg::*;

    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int CW = $clog2(SCREEN_COLUMNS);
    localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLUMNS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_TRIM,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [COLOR_W-1:0] r_fg, n_fg;
    logic [COLOR_W-1:0] r_bg, n_bg;
    logic [NUM_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [5:0]         r_bitcnt, n_bitcnt;
    logic [4:0]         r_ndig, n_ndig;

    logic               r_out_valid, n_out_valid;
    t_result_kind       r_out_kind, n_out_kind;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    logic [15:0]        r_out_word, n_out_word;
    logic [ROW_OUT_W-1:0] r_out_row, n_out_row;
    logic [COL_OUT_W-1:0] r_out_col, n_out_col;
    logic               r_out_last, n_out_last;

    logic               out_free;
    logic [RW-1:0]      row_inc;
    logic [RW-1:0]      adv_row;
    logic [CW-1:0]      adv_col;
    logic [CW:0]        tab_col;
    logic [AW-1:0]      cell_addr;
    logic [BCD_W-1:0]   bcd_fix;
    logic [3:0]         top_digit;
    logic [RW-1:0]      set_row;
    logic [CW-1:0]      set_col;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign top_digit  = r_bcd[BCD_W-1 -: 4];

    always_comb begin
        row_inc = (r_row == RW'(SCREEN_ROWS - 1)) ? '0 : r_row + 1'b1;
        if (r_col == CW'(SCREEN_COLUMNS - 1)) begin
            adv_col = '0;
            adv_row = row_inc;
        end else begin
            adv_col = r_col + 1'b1;
            adv_row = r_row;
        end
        tab_col   = ({1'b0, r_col} + (CW + 1)'(TAB_STEP)) & ~(CW + 1)'(TAB_STEP - 1);
        cell_addr = AW'(r_row) * AW'(SCREEN_COLUMNS) + AW'(r_col);
        set_row   = (i_target_row >= 8'(SCREEN_ROWS)) ? RW'(SCREEN_ROWS - 1)
                                                      : RW'(i_target_row);
        set_col   = (i_target_column >= 8'(SCREEN_COLUMNS)) ? CW'(SCREEN_COLUMNS - 1)
                                                            : CW'(i_target_column);
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_fix[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                           : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bitcnt    = r_bitcnt;
        n_ndig      = r_ndig;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;
        n_out_word  = r_out_word;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FOREGROUND: n_fg = i_cfg_wdata;
                REG_BACKGROUND: n_bg = i_cfg_wdata;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_out_kind = KIND_CURSOR;
                    n_out_addr = '0;
                    n_out_word = '0;
                    n_out_last = 1'b1;
                    unique case (i_opcode)
                        OP_PUT_CHAR: begin
                            n_out_valid = 1'b1;
                            case (i_char_code)
                                CH_NEWLINE: begin
                                    n_col = '0;
                                    n_row = row_inc;
                                end
                                CH_RETURN: begin
                                    n_col = '0;
                                end
                                CH_TAB: begin
                                    if (tab_col >= (CW + 1)'(SCREEN_COLUMNS)) begin
                                        n_col = '0;
                                        n_row = row_inc;
                                    end else begin
                                        n_col = CW'(tab_col);
                                    end
                                end
                                default: begin
                                    n_col      = adv_col;
                                    n_row      = adv_row;
                                    n_out_kind = KIND_CELL;
                                    n_out_addr = ADDR_W'(cell_addr);
                                    n_out_word = {r_bg, r_fg, i_char_code};
                                end
                            endcase
                        end
                        OP_PUT_NUMBER: begin
                            n_bin    = i_number_value;
                            n_bcd    = '0;
                            n_bitcnt = '0;
                            n_ndig   = 5'(NUM_DIGITS);
                            n_state  = S_CONVERT;
                        end
                        OP_SET_CURSOR: begin
                            n_out_valid = 1'b1;
                            n_row       = set_row;
                            n_col       = set_col;
                        end
                        OP_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_row       = '0;
                            n_col       = '0;
                            n_out_kind  = KIND_FILL;
                            n_out_word  = {r_bg, r_fg, CH_SPACE};
                        end
                        default: ;
                    endcase
                    n_out_row = ROW_OUT_W'(n_row);
                    n_out_col = COL_OUT_W'(n_col);
                end
            end
            S_CONVERT: begin
                n_bcd    = {bcd_fix[BCD_W-2:0], r_bin[NUM_BITS-1]};
                n_bin    = {r_bin[NUM_BITS-2:0], 1'b0};
                n_bitcnt = r_bitcnt + 1'b1;
                if (r_bitcnt == 6'(NUM_BITS - 1)) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if (top_digit == 4'd0 && r_ndig != 5'd1) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_CELL;
                    n_out_addr  = ADDR_W'(cell_addr);
                    n_out_word  = {r_bg, r_fg, CH_ZERO + {4'd0, top_digit}};
                    n_out_row   = ROW_OUT_W'(adv_row);
                    n_out_col   = COL_OUT_W'(adv_col);
                    n_out_last  = (r_ndig == 5'd1);
                    n_row       = adv_row;
                    n_col       = adv_col;
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig      = r_ndig - 1'b1;
                    if (r_ndig == 5'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_out_valid <= n_out_valid;
        end
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_bitcnt   <= n_bitcnt;
        r_ndig     <= n_ndig;
        r_out_kind <= n_out_kind;
        r_out_addr <= n_out_addr;
        r_out_word <= n_out_word;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out_kind;
    assign o_cell_address      = r_out_addr;
    assign o_cell_word         = r_out_word;
    assign o_cursor_row_out    = r_out_row;
    assign o_cursor_column_out = r_out_col;
    assign o_last_result       = r_out_last;

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= RW'(SCREEN_ROWS - 1)) && (r_col <= CW'(SCREEN_COLUMNS - 1)))
        else $error("cursor left the screen");

    a_no_result_while_converting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CONVERT || r_state == S_TRIM) && !r_out_valid) |=> !r_out_valid)
        else $error("result produced before conversion finished");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_ndig != 5'd0))
        else $error("digit emission with no digits left");

    a_number_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_ndig == 5'd1) |=>
            (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final digit not marked as last result");

endmodule
